// ===== rtl/core/shfr_pkg.sv =====
// Shared types and constants for the sync header frame receiver.
package shfr_pkg;

    localparam logic [7:0] HDR1 = 8'hAA;
    localparam logic [7:0] HDR2 = 8'hBB;
    localparam logic [5:0] LEN_SAT = 6'h3F;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_HEAD1,
        ST_HEAD2,
        ST_FUNC1,
        ST_FUNC2,
        ST_LEN1,
        ST_LEN2,
        ST_DATA,
        ST_CHECK
    } t_parse_state;

    typedef enum logic [2:0] {
        OP_START,
        OP_FUNC_LO,
        OP_FUNC_HI,
        OP_DATA,
        OP_CHECK,
        OP_ABORT
    } t_op;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_LEN_ERR  = 2'd2
    } t_status;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [5:0] len;
    } t_cmd;

endpackage

// ===== rtl/core/sync_header_frame_receiver_top.sv =====
// Top level of the sync header frame receiver.
//
// The input channel (i_valid, o_ready, i_rx_byte) takes one received byte per
// transfer. Frames are 0xAA 0xBB, a little-endian function code, a
// little-endian length, the payload and one checksum byte (8-bit sum of the
// payload). The output channel (o_valid, i_ready and the result fields) gives
// one result per finished frame or per length that exceeds MAX_PAYLOAD.
// A byte can be taken in every cycle while the command queue is not full. For
// the byte that ends the frame, the front end classifies it combinationally
// and writes a command into the queue, and the back end moves that command
// from the queue into the output register. While a result waits in the output
// register, the four-entry command queue keeps absorbing bytes; o_ready falls
// only once that queue is full. Reset returns the parser to hunting for the
// first header byte and empties the queue and the output register.
module sync_header_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_function_code,
    output logic [5:0]  o_payload_length,
    output logic [7:0]  o_state_word,
    output logic [7:0]  o_alarm_code,
    output logic [7:0]  o_switch_state
);
    import shfr_pkg::*;

    logic front_cmd_valid;
    t_cmd front_cmd;
    logic fifo_not_full;
    logic fifo_not_empty;
    t_cmd fifo_cmd;
    logic back_ready;

    shfr_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .o_cmd_valid (front_cmd_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (fifo_not_full)
    );

    shfr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_cmd_valid),
        .i_cmd       (front_cmd),
        .o_not_full  (fifo_not_full),
        .o_not_empty (fifo_not_empty),
        .o_cmd       (fifo_cmd),
        .i_pop       (back_ready)
    );

    shfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (fifo_not_empty),
        .i_cmd            (fifo_cmd),
        .o_cmd_ready      (back_ready),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_function_code  (o_function_code),
        .o_payload_length (o_payload_length),
        .o_state_word     (o_state_word),
        .o_alarm_code     (o_alarm_code),
        .o_switch_state   (o_switch_state)
    );

endmodule

// ===== rtl/core/shfr_front.sv =====
// Front end: tracks the frame structure and turns received bytes into commands.
module shfr_front #(
    parameter int MAX_PAYLOAD = 63
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_rx_byte,
    output logic           o_cmd_valid,
    output shfr_pkg::t_cmd o_cmd,
    input  logic           i_cmd_ready
);
    import shfr_pkg::*;

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    t_parse_state r_state, n_state;
    logic [7:0]   r_len, n_len;
    logic [7:0]   r_count, n_count;
    logic         accept;
    logic         len1_err;
    logic         len2_err;
    logic [8:0]   count_inc;
    logic [5:0]   len_sat;

    assign o_ready   = i_cmd_ready;
    assign accept    = i_valid && i_cmd_ready;
    assign len1_err  = {8'd0, i_rx_byte} > MAX_LEN;
    assign len2_err  = {i_rx_byte, r_len} > MAX_LEN;
    assign count_inc = {1'b0, r_count} + 9'd1;
    assign len_sat   = (r_len > {2'b00, LEN_SAT}) ? LEN_SAT : r_len[5:0];

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_count = r_count;
        case (r_state)
            ST_HEAD1: begin
                n_state = (i_rx_byte == HDR1) ? ST_HEAD2 : ST_HEAD1;
            end
            ST_HEAD2: begin
                if (i_rx_byte == HDR2) begin
                    n_state = ST_FUNC1;
                end else if (i_rx_byte == HDR1) begin
                    n_state = ST_HEAD2;
                end else begin
                    n_state = ST_HEAD1;
                end
            end
            ST_FUNC1: begin
                n_state = ST_FUNC2;
            end
            ST_FUNC2: begin
                n_state = ST_LEN1;
            end
            ST_LEN1: begin
                n_len = i_rx_byte;
                if (len1_err) begin
                    n_state = (i_rx_byte == HDR1) ? ST_HEAD2 : ST_HEAD1;
                end else begin
                    n_state = ST_LEN2;
                end
            end
            ST_LEN2: begin
                n_count = 8'd0;
                if (len2_err) begin
                    n_state = (i_rx_byte == HDR1) ? ST_HEAD2 : ST_HEAD1;
                end else begin
                    n_state = (r_len == 8'd0) ? ST_CHECK : ST_DATA;
                end
            end
            ST_DATA: begin
                n_count = count_inc[7:0];
                if (count_inc >= {1'b0, r_len}) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = ST_HEAD1;
            end
            default: begin
                n_state = ST_HEAD1;
            end
        endcase
    end

    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd.op    = OP_DATA;
        o_cmd.data  = i_rx_byte;
        o_cmd.len   = len_sat;
        case (r_state)
            ST_HEAD2: begin
                o_cmd_valid = i_valid && (i_rx_byte == HDR2);
                o_cmd.op    = OP_START;
            end
            ST_FUNC1: begin
                o_cmd_valid = i_valid;
                o_cmd.op    = OP_FUNC_LO;
            end
            ST_FUNC2: begin
                o_cmd_valid = i_valid;
                o_cmd.op    = OP_FUNC_HI;
            end
            ST_LEN1: begin
                o_cmd_valid = i_valid && len1_err;
                o_cmd.op    = OP_ABORT;
            end
            ST_LEN2: begin
                o_cmd_valid = i_valid && len2_err;
                o_cmd.op    = OP_ABORT;
            end
            ST_DATA: begin
                o_cmd_valid = i_valid;
                o_cmd.op    = OP_DATA;
            end
            ST_CHECK: begin
                o_cmd_valid = i_valid;
                o_cmd.op    = OP_CHECK;
            end
            default: begin
                o_cmd_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEAD1;
            r_len   <= 8'd0;
            r_count <= 8'd0;
        end else if (accept) begin
            r_state <= n_state;
            r_len   <= n_len;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/shfr_fifo.sv =====
// Short command queue between the front end and the back end.
module shfr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  shfr_pkg::t_cmd i_cmd,
    output logic           o_not_full,
    output logic           o_not_empty,
    output shfr_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import shfr_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_not_full  = r_count != FIFO_CNT_W'(FIFO_DEPTH);
    assign o_not_empty = r_count != '0;
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_cmd       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/shfr_back.sv =====
// Back end: accumulates frame fields and holds the result output register.
module shfr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  shfr_pkg::t_cmd i_cmd,
    output logic           o_cmd_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_status,
    output logic [15:0]    o_function_code,
    output logic [5:0]     o_payload_length,
    output logic [7:0]     o_state_word,
    output logic [7:0]     o_alarm_code,
    output logic [7:0]     o_switch_state
);
    import shfr_pkg::*;

    logic [15:0] r_func;
    logic [7:0]  r_sum;
    logic [7:0]  r_cap0;
    logic [7:0]  r_cap1;
    logic [7:0]  r_cap2;
    logic [1:0]  r_cap_idx;
    logic        r_out_valid;
    t_status     r_status;
    logic [15:0] r_out_func;
    logic [5:0]  r_out_len;
    logic [7:0]  r_out_cap0;
    logic [7:0]  r_out_cap1;
    logic [7:0]  r_out_cap2;
    logic        emits;
    logic        slot_free;
    logic        fire;

    assign emits       = (i_cmd.op == OP_CHECK) || (i_cmd.op == OP_ABORT);
    assign slot_free   = !r_out_valid || i_ready;
    assign o_cmd_ready = !emits || slot_free;
    assign fire        = i_cmd_valid && o_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func    <= 16'd0;
            r_sum     <= 8'd0;
            r_cap0    <= 8'd0;
            r_cap1    <= 8'd0;
            r_cap2    <= 8'd0;
            r_cap_idx <= 2'd0;
        end else if (fire) begin
            case (i_cmd.op)
                OP_START: begin
                    r_func    <= 16'd0;
                    r_sum     <= 8'd0;
                    r_cap0    <= 8'd0;
                    r_cap1    <= 8'd0;
                    r_cap2    <= 8'd0;
                    r_cap_idx <= 2'd0;
                end
                OP_FUNC_LO: begin
                    r_func <= {8'd0, i_cmd.data};
                end
                OP_FUNC_HI: begin
                    r_func[15:8] <= i_cmd.data;
                end
                OP_DATA: begin
                    r_sum <= r_sum + i_cmd.data;
                    if (r_cap_idx == 2'd0) begin
                        r_cap0 <= i_cmd.data;
                    end
                    if (r_cap_idx == 2'd1) begin
                        r_cap1 <= i_cmd.data;
                    end
                    if (r_cap_idx == 2'd2) begin
                        r_cap2 <= i_cmd.data;
                    end
                    if (r_cap_idx != 2'd3) begin
                        r_cap_idx <= r_cap_idx + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emits) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emits) begin
            r_out_func <= r_func;
            r_out_cap0 <= r_cap0;
            r_out_cap1 <= r_cap1;
            r_out_cap2 <= r_cap2;
            if (i_cmd.op == OP_ABORT) begin
                r_status  <= STATUS_LEN_ERR;
                r_out_len <= 6'd0;
            end else begin
                r_status  <= (r_sum == i_cmd.data) ? STATUS_GOOD : STATUS_MISMATCH;
                r_out_len <= i_cmd.len;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_function_code  = r_out_func;
    assign o_payload_length = r_out_len;
    assign o_state_word     = r_out_cap0;
    assign o_alarm_code     = r_out_cap1;
    assign o_switch_state   = r_out_cap2;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the sync header frame receiver, with its own frame parser model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import shfr_pkg::*;

    localparam int MAX_PAYLOAD = 63;
    localparam int BYTE_TARGET = 1300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        t_status     status;
        logic [15:0] function_code;
        logic [5:0]  payload_length;
        logic [7:0]  state_word;
        logic [7:0]  alarm_code;
        logic [7:0]  switch_state;
    } t_frame_result;

    typedef struct packed {
        logic [7:0]    rx_byte;
        logic          has_result;
        t_frame_result result;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [15:0] o_function_code;
    logic [5:0]  o_payload_length;
    logic [7:0]  o_state_word;
    logic [7:0]  o_alarm_code;
    logic [7:0]  o_switch_state;

    sync_header_frame_receiver_top #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_rx_byte(i_rx_byte),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_function_code(o_function_code),
        .o_payload_length(o_payload_length),
        .o_state_word(o_state_word),
        .o_alarm_code(o_alarm_code),
        .o_switch_state(o_switch_state)
    );

    // Parser model state.
    t_parse_state parser_state;
    logic [15:0]  frame_function;
    logic [15:0]  frame_length;
    logic [15:0]  payload_count;
    logic [7:0]   payload_sum;
    logic [7:0]   payload_head [3];

    t_frame_result pending_results [$];
    int error_count;
    int bytes_sent;
    int good_frames;
    int mismatch_frames;
    int length_errors;
    int sender_idle_pct;
    int receiver_stall_pct;

    t_script_row directed_script [0:26] = '{
        '{8'h00, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'hBB, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{STATUS_GOOD, 16'h0000, 6'd0, 8'h00, 8'h00, 8'h00}},
        '{8'hAA, 1'b0, '0},
        '{8'hBB, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hAA, 1'b1, '{STATUS_LEN_ERR, 16'hFFFF, 6'd0, 8'h00, 8'h00, 8'h00}},
        '{8'hBB, 1'b0, '0},
        '{8'h34, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hAA, 1'b1, '{STATUS_LEN_ERR, 16'h1234, 6'd0, 8'h00, 8'h00, 8'h00}},
        '{8'hBB, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h10, 1'b0, '0},
        '{8'h20, 1'b0, '0},
        '{8'h31, 1'b1, '{STATUS_MISMATCH, 16'h0001, 6'd2, 8'h10, 8'h20, 8'h00}}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_frame_result make_result(input t_status status, input logic [15:0] len);
        t_frame_result res;
        res.status         = status;
        res.function_code  = frame_function;
        res.payload_length = (len > 16'd63) ? LEN_SAT : len[5:0];
        res.state_word     = payload_head[0];
        res.alarm_code     = payload_head[1];
        res.switch_state   = payload_head[2];
        return res;
    endfunction

    task automatic parse_byte(input logic [7:0] b, output bit produced,
                              output t_frame_result res);
        produced = 1'b0;
        res = '0;
        case (parser_state)
            ST_HEAD1: begin
                parser_state = (b == HDR1) ? ST_HEAD2 : ST_HEAD1;
            end
            ST_HEAD2: begin
                if (b == HDR2) begin
                    frame_function = '0;
                    frame_length   = '0;
                    payload_count  = '0;
                    payload_sum    = '0;
                    payload_head   = '{8'h00, 8'h00, 8'h00};
                    parser_state   = ST_FUNC1;
                end else if (b == HDR1) begin
                    parser_state = ST_HEAD2;
                end else begin
                    parser_state = ST_HEAD1;
                end
            end
            ST_FUNC1: begin
                frame_function = {8'h00, b};
                parser_state   = ST_FUNC2;
            end
            ST_FUNC2: begin
                frame_function[15:8] = b;
                parser_state         = ST_LEN1;
            end
            ST_LEN1, ST_LEN2: begin
                if (parser_state == ST_LEN1) begin
                    frame_length = {8'h00, b};
                end else begin
                    frame_length[15:8] = b;
                end
                if (frame_length > 16'(MAX_PAYLOAD)) begin
                    res          = make_result(STATUS_LEN_ERR, 16'd0);
                    produced     = 1'b1;
                    frame_length = '0;
                    parser_state = (b == HDR1) ? ST_HEAD2 : ST_HEAD1;
                end else if (parser_state == ST_LEN1) begin
                    parser_state = ST_LEN2;
                end else begin
                    payload_count = '0;
                    parser_state  = (frame_length == 16'd0) ? ST_CHECK : ST_DATA;
                end
            end
            ST_DATA: begin
                if (payload_count < 16'd3) begin
                    payload_head[payload_count] = b;
                end
                payload_sum   = payload_sum + b;
                payload_count = payload_count + 16'd1;
                if (payload_count >= frame_length) begin
                    parser_state = ST_CHECK;
                end
            end
            default: begin
                res = make_result((payload_sum == b) ? STATUS_GOOD : STATUS_MISMATCH,
                                  frame_length);
                produced     = 1'b1;
                parser_state = ST_HEAD1;
            end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [7:0] b, input logic has_fixed,
                             input t_frame_result fixed);
        bit            produced;
        t_frame_result predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        parse_byte(b, produced, predicted);
        if (has_fixed) begin
            pending_results.push_back(fixed);
        end else if (produced) begin
            pending_results.push_back(predicted);
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_frame();
        logic [15:0] func;
        logic [7:0]  len_lo;
        logic [7:0]  len_hi;
        logic [7:0]  data;
        logic [7:0]  sum;
        int          kind;
        int          len;
        kind = $urandom_range(99);
        func = 16'($urandom_range(65535));
        len_hi = 8'h00;
        len = 0;
        if (kind < 55) begin
            len = $urandom_range(8);
        end else if (kind < 65) begin
            len = MAX_PAYLOAD;
        end else if (kind < 72) begin
            len = $urandom_range(MAX_PAYLOAD - 1, 9);
        end
        len_lo = 8'(len);
        if (kind >= 72 && kind < 82) begin
            case ($urandom_range(3))
                0: len_lo = 8'(MAX_PAYLOAD + 1);
                1: len_lo = HDR1;
                2: len_lo = 8'hFF;
                default: len_lo = 8'($urandom_range(255, MAX_PAYLOAD + 1));
            endcase
        end else if (kind >= 82 && kind < 90) begin
            len_lo = 8'($urandom_range(255));
            case ($urandom_range(3))
                0: len_hi = 8'h01;
                1: len_hi = HDR1;
                2: len_hi = 8'hFF;
                default: len_hi = 8'($urandom_range(255, 1));
            endcase
        end
        send_byte(HDR1, 1'b0, '0);
        send_byte(HDR2, 1'b0, '0);
        if (kind >= 90) begin
            repeat ($urandom_range(5)) send_byte(8'($urandom_range(255)), 1'b0, '0);
            return;
        end
        send_byte(func[7:0], 1'b0, '0);
        send_byte(func[15:8], 1'b0, '0);
        send_byte(len_lo, 1'b0, '0);
        if (kind >= 72 && kind < 82) begin
            return;
        end
        send_byte(len_hi, 1'b0, '0);
        if (kind >= 82) begin
            return;
        end
        sum = '0;
        for (int i = 0; i < len; i++) begin
            data = 8'($urandom_range(255));
            sum  = sum + data;
            send_byte(data, 1'b0, '0);
        end
        if ($urandom_range(99) < 70) begin
            send_byte(sum, 1'b0, '0);
        end else begin
            send_byte(8'($urandom_range(255)), 1'b0, '0);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_status, o_function_code, o_payload_length,
                   o_state_word, o_alarm_code, o_switch_state};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 16'(want.status), 16'(got.status));
                compare_field("function_code", want.function_code, got.function_code);
                compare_field("payload_length", 16'(want.payload_length),
                              16'(got.payload_length));
                compare_field("state_word", 16'(want.state_word), 16'(got.state_word));
                compare_field("alarm_code", 16'(want.alarm_code), 16'(got.alarm_code));
                compare_field("switch_state", 16'(want.switch_state), 16'(got.switch_state));
            end
            case (got.status)
                STATUS_GOOD:     good_frames++;
                STATUS_MISMATCH: mismatch_frames++;
                default:         length_errors++;
            endcase
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_rx_byte          = 8'h00;
        i_ready            = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        error_count        = 0;
        bytes_sent         = 0;
        good_frames        = 0;
        mismatch_frames    = 0;
        length_errors      = 0;
        parser_state       = ST_HEAD1;
        frame_function     = '0;
        frame_length       = '0;
        payload_count      = '0;
        payload_sum        = '0;
        payload_head       = '{8'h00, 8'h00, 8'h00};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_script[i]) begin
            send_byte(directed_script[i].rx_byte, directed_script[i].has_result,
                      directed_script[i].result);
        end

        while (bytes_sent < BYTE_TARGET) begin
            case ((bytes_sent * 4) / BYTE_TARGET)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
                default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
            endcase
            if ($urandom_range(99) < 25) begin
                repeat ($urandom_range(3, 1)) begin
                    send_byte(($urandom_range(3) == 0) ? HDR1 : 8'($urandom_range(255)),
                              1'b0, '0);
                end
            end
            send_random_frame();
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes under four handshake pacing phases.", bytes_sent);
        $display("Results seen: %0d good, %0d checksum mismatch, %0d length error.",
                 good_frames, mismatch_frames, length_errors);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/shfr_pkg.sv
rtl/core/shfr_front.sv
rtl/core/shfr_fifo.sv
rtl/core/shfr_back.sv
rtl/core/sync_header_frame_receiver_top.sv
tb/sv/tb_top.sv
